// File: rtl/lkrb_pkg.sv
// Shared types, constants and defaults of the layered keymap report builder.
package lkrb_pkg;

	localparam int KEYS_PER_HALF_DEF = 24;
	localparam int REPORT_SLOTS_DEF  = 6;
	localparam int LAYER_COUNT_DEF   = 3;

	localparam int OUT_SLOTS = 6;
	localparam int KEY_W     = 24;
	localparam int MAX_KEYS  = 64;
	localparam int CODE_W    = 8;
	localparam int LAYER_W   = 2;
	localparam int POS_W     = 6;
	localparam int COUNT_W   = $clog2(OUT_SLOTS + 1);

	localparam logic [CODE_W-1:0] CMD_BASE   = 8'hF0;
	localparam logic [CODE_W-1:0] CMD_TOGGLE = 8'hF0;

	localparam logic ACT_SCAN  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef struct packed {
		logic               action;
		logic [KEY_W-1:0]   local_keys;
		logic [KEY_W-1:0]   remote_keys;
		logic               report_enabled;
		logic [LAYER_W-1:0] entry_layer;
		logic [POS_W-1:0]   entry_position;
		logic [CODE_W-1:0]  entry_code;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0]  slot0;
		logic [CODE_W-1:0]  slot1;
		logic [CODE_W-1:0]  slot2;
		logic [CODE_W-1:0]  slot3;
		logic [CODE_W-1:0]  slot4;
		logic [CODE_W-1:0]  slot5;
		logic               report_changed;
		logic [LAYER_W-1:0] layer_now;
	} report_t;

endpackage

// File: rtl/lkrb_keymap.sv
// Keymap memory: one write port, two registered read ports.
module lkrb_keymap #(
	parameter int DEPTH = 144,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [lkrb_pkg::CODE_W-1:0] wr_data,
	input  logic [AW-1:0]         rd_addr0,
	input  logic [AW-1:0]         rd_addr1,
	output logic [lkrb_pkg::CODE_W-1:0] rd_data0,
	output logic [lkrb_pkg::CODE_W-1:0] rd_data1
);
	import lkrb_pkg::*;

	logic [CODE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data0 <= mem_q[rd_addr0];
		rd_data1 <= mem_q[rd_addr1];
	end

endmodule

// File: rtl/layered_keymap_report_builder.sv
// Top level: scan sequencer, shared key evaluator and report register.
// An enabled scan walks every key position, one a cycle via both keymap read ports, then
// loads the report in the finishing state; a disabled scan goes straight to the finishing
// state, and a keymap write gives no result. One transaction at a time: a new one is taken
// only back in idle, and a report still held waits in the finishing state.
// Reset clears layer, previous report and control; the keymap is not cleared.
module layered_keymap_report_builder #(
	parameter int KEYS_PER_HALF = lkrb_pkg::KEYS_PER_HALF_DEF,
	parameter int REPORT_SLOTS  = lkrb_pkg::REPORT_SLOTS_DEF,
	parameter int LAYER_COUNT   = lkrb_pkg::LAYER_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lkrb_pkg::item_t   item,
	output logic              report_valid,
	input  logic              report_stall,
	output lkrb_pkg::report_t report
);
	import lkrb_pkg::*;

	localparam int KPL   = 2 * KEYS_PER_HALF;          // positions per layer
	localparam int DEPTH = LAYER_COUNT * KPL;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(KPL + 1);
	localparam int USED  = (REPORT_SLOTS < OUT_SLOTS) ? REPORT_SLOTS : OUT_SLOTS;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

	state_t            state_q;
	logic [PW-1:0]     pos_q;
	logic [KPL-1:0]    keys_q;        // pressed bits, bit 0 is the position being read
	logic              rd_valid_s1;
	logic              pressed_s1;
	logic [COUNT_W-1:0] count_q;
	logic [LAYER_W-1:0] layer_q;
	logic [CODE_W-1:0] rep_q  [OUT_SLOTS];
	logic [CODE_W-1:0] last_q [OUT_SLOTS];
	logic              report_valid_q;
	report_t           report_q;

	// Keymap write and read ports
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr0;
	logic [AW-1:0]     rd_addr1;
	logic [CODE_W-1:0] rd_data0;
	logic [CODE_W-1:0] rd_data1;

	// Scan load
	logic [MAX_KEYS-1:0] local_ext;
	logic [MAX_KEYS-1:0] remote_ext;
	logic [KPL-1:0]      keys_load;

	// Shared key evaluator
	logic [CODE_W-1:0] code;
	logic              eval;
	logic              place;
	logic              toggle;
	logic              changed;
	logic              out_free;
	logic              accept;
	logic              emit;

	assign accept   = item_valid && !item_stall;
	assign out_free = !report_valid_q || !report_stall;
	assign emit     = (state_q == S_DONE) && out_free;

	assign wr_en   = accept && (item.action == ACT_WRITE)
		&& (int'(item.entry_layer) < LAYER_COUNT)
		&& (int'(item.entry_position) < KPL);
	assign wr_addr = AW'(AW'(item.entry_layer) * AW'(KPL)) + AW'(item.entry_position);

	// Both candidate layers are read together; the layer in force picks one from the
	// registered read data, so a toggle on one key already steers the next.
	assign rd_addr0 = AW'(pos_q);
	assign rd_addr1 = AW'(KPL) + AW'(pos_q);

	lkrb_keymap #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_keymap (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (item.entry_code),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1)
	);

	always_comb begin
		local_ext  = MAX_KEYS'(item.local_keys);
		remote_ext = MAX_KEYS'(item.remote_keys);
		keys_load  = '0;
		for (int i = 0; i < KEYS_PER_HALF; i++) begin
			keys_load[i]                 = local_ext[i];
			keys_load[KEYS_PER_HALF + i] = remote_ext[i];
		end
	end

	// One key a cycle: while a slot is free, toggle on CMD_TOGGLE, skip blanks and other commands, else fill a slot
	always_comb begin
		code   = (layer_q == '0) ? rd_data0 : rd_data1;
		eval   = rd_valid_s1 && pressed_s1 && (count_q < COUNT_W'(USED));
		toggle = eval && (code == CMD_TOGGLE);
		place  = eval && (code < CMD_BASE) && (code != '0);
	end

	always_comb begin
		changed = 1'b0;
		for (int j = 0; j < OUT_SLOTS; j++) begin
			if (rep_q[j] != last_q[j]) begin
				changed = 1'b1;
			end
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign report_valid = report_valid_q;
	assign report       = report_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pos_q          <= '0;
			keys_q         <= '0;
			rd_valid_s1    <= 1'b0;
			pressed_s1     <= 1'b0;
			count_q        <= '0;
			layer_q        <= '0;
			report_valid_q <= 1'b0;
			report_q       <= '0;
			for (int j = 0; j < OUT_SLOTS; j++) begin
				rep_q[j]  <= '0;
				last_q[j] <= '0;
			end
		end else begin
			// a new report replaces one taken in the same cycle
			if (emit) begin
				report_valid_q <= 1'b1;
			end else if (report_valid_q && !report_stall) begin
				report_valid_q <= 1'b0;
			end

			if (toggle) begin
				layer_q <= (layer_q == '0) ? LAYER_W'(1) : '0;
			end
			if (place) begin
				for (int j = 0; j < USED; j++) begin
					if (count_q == COUNT_W'(j)) begin
						rep_q[j] <= code;
					end
				end
				count_q <= count_q + COUNT_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					rd_valid_s1 <= 1'b0;
					if (accept && (item.action == ACT_SCAN)) begin
						for (int j = 0; j < OUT_SLOTS; j++) begin
							rep_q[j] <= '0;
						end
						count_q <= '0;
						pos_q   <= '0;
						keys_q  <= keys_load;
						state_q <= item.report_enabled ? S_WALK : S_DONE;
					end
				end
				S_WALK: begin
					if (pos_q != PW'(KPL)) begin
						rd_valid_s1 <= 1'b1;
						pressed_s1  <= keys_q[0];
						keys_q      <= keys_q >> 1;
						pos_q       <= pos_q + PW'(1);
					end else begin
						// last position is evaluated in this cycle
						rd_valid_s1 <= 1'b0;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						report_q.slot0          <= rep_q[0];
						report_q.slot1          <= rep_q[1];
						report_q.slot2          <= rep_q[2];
						report_q.slot3          <= rep_q[3];
						report_q.slot4          <= rep_q[4];
						report_q.slot5          <= rep_q[5];
						report_q.report_changed <= changed;
						report_q.layer_now      <= layer_q;
						for (int j = 0; j < OUT_SLOTS; j++) begin
							last_q[j] <= rep_q[j];
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The slot count never passes the report size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(USED))
		else $error("slot count beyond report size");

	// Only layers 0 and 1 are ever active
	a_layer_range: assert property (@(posedge clk) disable iff (!arst_n)
		layer_q == LAYER_W'(0) || layer_q == LAYER_W'(1))
		else $error("active layer outside toggle pair");

	// A new result comes only from the finishing state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(report_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside finishing state");

	// Keys are evaluated only while walking or on the step into the finish
	a_eval_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_WALK && pos_q != '0))
		else $error("key evaluated outside walk");

endmodule
